// File: rtl/tkvp_pkg.sv
package tkvp_pkg;

    localparam int WIN_BYTES = 8;
    localparam int NUM_VALS = 5;
    localparam logic [26:0] MAG_CAP = 27'd100000000;
    localparam logic [26:0] TEMP_POS_MAX = 27'd3276700;
    localparam logic [26:0] TEMP_NEG_MAX = 27'd3276800;

    // key phases
    localparam logic [1:0] PH_SEARCH = 2'd0;
    localparam logic [1:0] PH_VALUE = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    // number parse stages
    localparam logic [1:0] ST_SKIP = 2'd0;
    localparam logic [1:0] ST_INT = 2'd1;
    localparam logic [1:0] ST_FRAC = 2'd2;
    localparam logic [1:0] ST_STOP = 2'd3;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] chr;
        logic       last;
        logic       live;
        logic [5:0] hit;
    } cls_t;

    typedef struct packed {
        logic signed [22:0] cpu_temp_centi;
        logic [15:0]        cpu_load;
        logic signed [22:0] gpu_temp_centi;
        logic [15:0]        gpu_load;
        logic [15:0]        ram_usage;
        logic [7:0]         time_hour;
        logic [7:0]         time_minute;
        logic [7:0]         time_second;
        logic               time_seen;
    } res_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39);
    endfunction

endpackage

// File: rtl/tkvp_front.sv
module tkvp_front
    import tkvp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic [7:0] chr,
    input  logic       last,
    output cls_t       cls
);

    logic [7:0] win_reg [WIN_BYTES];
    logic [7:0] win_next [WIN_BYTES];
    logic       over_reg;
    logic       live;

    assign live = !over_reg && (chr != 8'h00);

    // window after shifting in the current byte
    always_comb
    begin
        for (int i = 0; i < WIN_BYTES - 1; i++)
        begin
            win_next[i] = win_reg[i + 1];
        end
        win_next[WIN_BYTES - 1] = chr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            over_reg <= 1'b0;
            for (int i = 0; i < WIN_BYTES; i++)
            begin
                win_reg[i] <= 8'h00;
            end
        end
        else if (in_fire)
        begin
            if (last)
            begin
                over_reg <= 1'b0;
                for (int i = 0; i < WIN_BYTES; i++)
                begin
                    win_reg[i] <= 8'h00;
                end
            end
            else
            begin
                if (chr == 8'h00)
                begin
                    over_reg <= 1'b1;
                end
                if (live)
                begin
                    win_reg <= win_next;
                end
            end
        end
    end

    // key tail compares
    always_comb
    begin
        cls.chr  = chr;
        cls.last = last;
        cls.live = live;
        cls.hit[0] = {win_next[0], win_next[1], win_next[2], win_next[3], win_next[4],
                      win_next[5], win_next[6], win_next[7]} == "CPUTemp:";
        cls.hit[1] = {win_next[0], win_next[1], win_next[2], win_next[3], win_next[4],
                      win_next[5], win_next[6], win_next[7]} == "CPULoad:";
        cls.hit[2] = {win_next[0], win_next[1], win_next[2], win_next[3], win_next[4],
                      win_next[5], win_next[6], win_next[7]} == "GPUTemp:";
        cls.hit[3] = {win_next[0], win_next[1], win_next[2], win_next[3], win_next[4],
                      win_next[5], win_next[6], win_next[7]} == "GPULoad:";
        cls.hit[4] = {win_next[4], win_next[5], win_next[6], win_next[7]} == "RAM:";
        cls.hit[5] = {win_next[3], win_next[4], win_next[5], win_next[6],
                      win_next[7]} == "Time:";
    end

endmodule

// File: rtl/tkvp_back.sv
module tkvp_back
    import tkvp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  cls_t cls,
    output logic done,
    output res_t res
);

    logic [1:0]  phase_reg [6];
    logic [1:0]  stg_reg [NUM_VALS];
    logic        neg_reg [NUM_VALS];
    logic [1:0]  frac_reg [NUM_VALS];
    logic [26:0] mag_reg [NUM_VALS];
    logic [1:0]  tstg_reg [3];
    logic        tneg_reg [3];
    logic [7:0]  tmag_reg [3];
    logic [1:0]  tidx_reg;
    logic [7:0]  held_reg [3];

    logic [1:0]  phase_next [6];
    logic [1:0]  stg_next [NUM_VALS];
    logic        neg_next [NUM_VALS];
    logic [1:0]  frac_next [NUM_VALS];
    logic [26:0] mag_next [NUM_VALS];
    logic [1:0]  tstg_next [3];
    logic        tneg_next [3];
    logic [7:0]  tmag_next [3];
    logic [1:0]  tidx_next;
    logic [7:0]  held_next [3];

    logic [7:0]  c;
    logic        dig;
    logic        spc;
    logic [3:0]  d;
    logic [29:0] sum;
    logic [7:0]  t8;
    logic        tin_int;

    assign c   = cls.chr;
    assign dig = is_digit(c);
    assign spc = is_space(c);
    assign d   = c[3:0];

    // per byte value parsing
    always_comb
    begin
        phase_next = phase_reg;
        stg_next   = stg_reg;
        neg_next   = neg_reg;
        frac_next  = frac_reg;
        mag_next   = mag_reg;
        tstg_next  = tstg_reg;
        tneg_next  = tneg_reg;
        tmag_next  = tmag_reg;
        tidx_next  = tidx_reg;
        held_next  = held_reg;
        sum        = '0;
        t8         = '0;
        tin_int    = 1'b0;
        if (cls.live)
        begin
            for (int k = 0; k < NUM_VALS; k++)
            begin
                if (phase_reg[k] == PH_VALUE)
                begin
                    if (c == ",")
                    begin
                        phase_next[k] = PH_DONE;
                    end
                    else
                    begin
                        unique case (stg_reg[k])
                            ST_SKIP:
                            begin
                                if (spc)
                                begin
                                    stg_next[k] = ST_SKIP;
                                end
                                else if (c == "+" || c == "-")
                                begin
                                    neg_next[k] = (c == "-");
                                    stg_next[k] = ST_INT;
                                end
                                else if (dig)
                                begin
                                    stg_next[k] = ST_INT;
                                    mag_next[k] = 27'(d) * 27'd100;
                                end
                                else if (c == ".")
                                begin
                                    stg_next[k] = ST_FRAC;
                                end
                                else
                                begin
                                    stg_next[k] = ST_STOP;
                                end
                            end
                            ST_INT:
                            begin
                                if (dig)
                                begin
                                    sum = 30'(mag_reg[k]) * 30'd10 + 30'(d) * 30'd100;
                                    mag_next[k] = (sum > 30'(MAG_CAP)) ? MAG_CAP
                                                                       : sum[26:0];
                                end
                                else if (c == ".")
                                begin
                                    stg_next[k] = ST_FRAC;
                                end
                                else
                                begin
                                    stg_next[k] = ST_STOP;
                                end
                            end
                            ST_FRAC:
                            begin
                                if (dig)
                                begin
                                    if (frac_reg[k] == 2'd0)
                                    begin
                                        sum = 30'(mag_reg[k]) + 30'(d) * 30'd10;
                                    end
                                    else if (frac_reg[k] == 2'd1)
                                    begin
                                        sum = 30'(mag_reg[k]) + 30'(d);
                                    end
                                    else
                                    begin
                                        sum = 30'(mag_reg[k]);
                                    end
                                    if (frac_reg[k] != 2'd2)
                                    begin
                                        frac_next[k] = frac_reg[k] + 2'd1;
                                    end
                                    mag_next[k] = (sum > 30'(MAG_CAP)) ? MAG_CAP
                                                                       : sum[26:0];
                                end
                                else
                                begin
                                    stg_next[k] = ST_STOP;
                                end
                            end
                            default:
                            begin
                                stg_next[k] = ST_STOP;
                            end
                        endcase
                    end
                end
            end
            // time fields
            if (phase_reg[5] == PH_VALUE && tidx_reg != 2'd3)
            begin
                if (c == ((tidx_reg == 2'd2) ? 8'h0A : "-"))
                begin
                    tidx_next = tidx_reg + 2'd1;
                    if (tidx_reg == 2'd2)
                    begin
                        phase_next[5] = PH_DONE;
                    end
                end
                else
                begin
                    unique case (tstg_reg[tidx_reg])
                        ST_SKIP:
                        begin
                            if (spc)
                            begin
                                tin_int = 1'b0;
                            end
                            else if (c == "+" || c == "-")
                            begin
                                tneg_next[tidx_reg] = (c == "-");
                                tstg_next[tidx_reg] = ST_INT;
                            end
                            else if (dig)
                            begin
                                tstg_next[tidx_reg] = ST_INT;
                                tin_int = 1'b1;
                            end
                            else
                            begin
                                tstg_next[tidx_reg] = ST_STOP;
                            end
                        end
                        ST_INT:
                        begin
                            if (dig)
                            begin
                                tin_int = 1'b1;
                            end
                            else
                            begin
                                tstg_next[tidx_reg] = ST_STOP;
                            end
                        end
                        default:
                        begin
                            tstg_next[tidx_reg] = ST_STOP;
                        end
                    endcase
                    if (tin_int)
                    begin
                        t8 = 8'(tmag_reg[tidx_reg] * 8'd10) + 8'(d);
                        tmag_next[tidx_reg] = t8;
                    end
                end
            end
            // key hits, first occurrence only
            for (int k = 0; k < 6; k++)
            begin
                if (phase_reg[k] == PH_SEARCH && cls.hit[k])
                begin
                    phase_next[k] = PH_VALUE;
                end
            end
        end
        // latch time at end of message
        if (phase_next[5] != PH_SEARCH)
        begin
            for (int f = 0; f < 3; f++)
            begin
                held_next[f] = tneg_next[f] ? 8'(8'd0 - tmag_next[f]) : tmag_next[f];
            end
        end
    end

    // result formatting from the final state
    function automatic logic [22:0] temp_fmt(input logic [1:0] ph, input logic ng,
                                             input logic [26:0] m);
        logic [26:0] mm;
        mm = m;
        if (ph == PH_SEARCH)
        begin
            return '0;
        end
        if (ng)
        begin
            if (mm > TEMP_NEG_MAX)
            begin
                mm = TEMP_NEG_MAX;
            end
            return 23'(27'd0 - mm);
        end
        if (mm > TEMP_POS_MAX)
        begin
            mm = TEMP_POS_MAX;
        end
        return mm[22:0];
    endfunction

    // divide by 100 through a reciprocal multiply, exact below the saturation point
    function automatic logic [15:0] load_fmt(input logic [1:0] ph, input logic ng,
                                             input logic [26:0] m);
        logic [46:0] prod;
        prod = 47'(m[22:0]) * 47'd10737419;
        if (ph == PH_SEARCH || ng)
        begin
            return '0;
        end
        if (m >= 27'd6553600)
        begin
            return 16'hFFFF;
        end
        return prod[45:30];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done     <= 1'b0;
            tidx_reg <= '0;
            for (int k = 0; k < 6; k++)
            begin
                phase_reg[k] <= PH_SEARCH;
            end
            for (int k = 0; k < NUM_VALS; k++)
            begin
                stg_reg[k]  <= ST_SKIP;
                neg_reg[k]  <= 1'b0;
                frac_reg[k] <= '0;
                mag_reg[k]  <= '0;
            end
            for (int f = 0; f < 3; f++)
            begin
                tstg_reg[f] <= ST_SKIP;
                tneg_reg[f] <= 1'b0;
                tmag_reg[f] <= '0;
                held_reg[f] <= '0;
            end
        end
        else
        begin
            done <= step && cls.last;
            if (step)
            begin
                if (cls.last)
                begin
                    held_reg <= held_next;
                    res.cpu_temp_centi <= temp_fmt(phase_next[0], neg_next[0], mag_next[0]);
                    res.cpu_load       <= load_fmt(phase_next[1], neg_next[1], mag_next[1]);
                    res.gpu_temp_centi <= temp_fmt(phase_next[2], neg_next[2], mag_next[2]);
                    res.gpu_load       <= load_fmt(phase_next[3], neg_next[3], mag_next[3]);
                    res.ram_usage      <= load_fmt(phase_next[4], neg_next[4], mag_next[4]);
                    res.time_hour      <= held_next[0];
                    res.time_minute    <= held_next[1];
                    res.time_second    <= held_next[2];
                    res.time_seen      <= (phase_next[5] != PH_SEARCH);
                    tidx_reg <= '0;
                    for (int k = 0; k < 6; k++)
                    begin
                        phase_reg[k] <= PH_SEARCH;
                    end
                    for (int k = 0; k < NUM_VALS; k++)
                    begin
                        stg_reg[k]  <= ST_SKIP;
                        neg_reg[k]  <= 1'b0;
                        frac_reg[k] <= '0;
                        mag_reg[k]  <= '0;
                    end
                    for (int f = 0; f < 3; f++)
                    begin
                        tstg_reg[f] <= ST_SKIP;
                        tneg_reg[f] <= 1'b0;
                        tmag_reg[f] <= '0;
                    end
                end
                else
                begin
                    phase_reg <= phase_next;
                    stg_reg   <= stg_next;
                    neg_reg   <= neg_next;
                    frac_reg  <= frac_next;
                    mag_reg   <= mag_next;
                    tstg_reg  <= tstg_next;
                    tneg_reg  <= tneg_next;
                    tmag_reg  <= tmag_next;
                    tidx_reg  <= tidx_next;
                end
            end
        end
    end

endmodule

// File: rtl/telemetry_key_value_parser_top.sv
// Telemetry key/value parser: one message enters on s_axis, one byte per request,
// with tlast on its final byte; one result per message leaves on m_axis. A byte is
// taken every cycle while the byte queue and the output queue have room. The front
// stage tracks the key window and classifies each byte; a two-entry queue carries
// it to the back stage, which updates all value parsers together and registers the
// result; it then waits in a two-entry output queue while input keeps flowing.
module telemetry_key_value_parser_top
    import tkvp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // byte_in
    input  logic         s_axis_tlast,   // last_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // cpu_temp_centi, cpu_load, gpu_temp_centi, gpu_load, ram_usage,
    // time_hour, time_minute, time_second, time_seen, zero pad to 120
    output logic [119:0] m_axis_tdata
);

    cls_t       cls;
    cls_t       q_reg [2];
    logic [1:0] qcnt_reg;
    logic [1:0] q_wr;
    logic       in_fire;
    logic       step;
    logic       done;
    res_t       res;
    res_t       oq_reg [2];
    logic [1:0] ocnt_reg;
    logic [1:0] oq_wr;
    logic [1:0] pend_reg;
    logic       out_fire;

    // keep in flight results plus queued results within the output queue
    assign s_axis_tready = (qcnt_reg < 2'd2) && (32'(ocnt_reg) + 32'(pend_reg) < 32'd2);
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign step     = qcnt_reg != 2'd0;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign q_wr     = qcnt_reg - 2'(step);
    assign oq_wr    = ocnt_reg - 2'(out_fire);

    tkvp_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .chr     (s_axis_tdata),
        .last    (s_axis_tlast),
        .cls     (cls)
    );

    // front to back queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qcnt_reg <= '0;
        end
        else
        begin
            if (in_fire && q_wr == 2'd0)
            begin
                q_reg[0] <= cls;
            end
            else if (step)
            begin
                q_reg[0] <= q_reg[1];
            end
            if (in_fire && q_wr == 2'd1)
            begin
                q_reg[1] <= cls;
            end
            qcnt_reg <= qcnt_reg + 2'(in_fire) - 2'(step);
        end
    end

    tkvp_back u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .cls   (q_reg[0]),
        .done  (done),
        .res   (res)
    );

    // messages accepted but not yet in the output queue, and the output queue itself
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            ocnt_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 2'(in_fire && s_axis_tlast) - 2'(done);
            ocnt_reg <= ocnt_reg + 2'(done) - 2'(out_fire);
            if (done && oq_wr == 2'd0)
            begin
                oq_reg[0] <= res;
            end
            else if (out_fire)
            begin
                oq_reg[0] <= oq_reg[1];
            end
            if (done && oq_wr == 2'd1)
            begin
                oq_reg[1] <= res;
            end
        end
    end

    assign m_axis_tvalid = ocnt_reg != 2'd0;
    assign m_axis_tdata  = {1'b0, oq_reg[0].time_seen, oq_reg[0].time_second,
                            oq_reg[0].time_minute, oq_reg[0].time_hour,
                            oq_reg[0].ram_usage, oq_reg[0].gpu_load,
                            oq_reg[0].gpu_temp_centi, oq_reg[0].cpu_load,
                            oq_reg[0].cpu_temp_centi};

    a_qcnt: assert property (@(posedge clk) disable iff (!rst_n) qcnt_reg <= 2'd2)
        else $error("byte queue overflow");
    a_ocnt: assert property (@(posedge clk) disable iff (!rst_n)
        32'(ocnt_reg) + 32'(pend_reg) <= 32'd2)
        else $error("result queue overflow");
    a_done: assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(pend_reg) != 2'd0)
        else $error("result without message");

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import tkvp_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;   // byte_in
    logic         s_axis_tlast;   // last_byte
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // cpu_temp_centi, cpu_load, gpu_temp_centi, gpu_load, ram_usage,
    // time_hour, time_minute, time_second, time_seen, zero pad to 120
    logic [119:0] m_axis_tdata;

    telemetry_key_value_parser_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // one number being read: sign, stage, fraction digits, magnitude
    typedef struct {
        logic [1:0]  stage;
        bit          neg;
        int unsigned frac;
        int unsigned mag;
    } num_t;

    // parser copy
    byte unsigned win[WIN_BYTES];
    logic [1:0]   phase[6];
    num_t         vals[NUM_VALS];
    num_t         tfld[3];
    int unsigned  tidx;
    logic [7:0]   hold_t[3];
    bit           text_end;

    string key_str[6] = '{"CPUTemp:", "CPULoad:", "GPUTemp:", "GPULoad:", "RAM:", "Time:"};

    res_t   pending_reports[$];
    int     errors;
    int     bytes_sent;
    int     reports_seen;
    int     cycles;
    bit     long_stall;
    bit     sender_on;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void msg_clear();
        foreach (win[i]) win[i] = 0;
        foreach (phase[i]) phase[i] = PH_SEARCH;
        foreach (vals[i]) vals[i] = '{ST_SKIP, 0, 0, 0};
        foreach (tfld[i]) tfld[i] = '{ST_SKIP, 0, 0, 0};
        tidx = 0;
        text_end = 0;
    endfunction

    function automatic void num_take(ref num_t v, input byte unsigned c, input bit wrap8);
        bit dig;
        int unsigned d;
        bit sp;
        dig = (c >= "0" && c <= "9");
        d = c - 8'h30;
        sp = (c == " ") || (c >= 8'h09 && c <= 8'h0D);
        if (v.stage == ST_SKIP)
        begin
            if (sp) return;
            if (c == "+" || c == "-")
            begin
                v.neg = (c == "-");
                v.stage = ST_INT;
                return;
            end
            if (!dig && !(c == "." && !wrap8))
            begin
                v.stage = ST_STOP;
                return;
            end
            v.stage = ST_INT;
        end
        if (v.stage == ST_INT)
        begin
            if (dig)
            begin
                if (wrap8)
                    v.mag = (v.mag * 10 + d) & 8'hFF;
                else
                begin
                    v.mag = v.mag * 10 + d * 100;
                    if (v.mag > MAG_CAP) v.mag = MAG_CAP;
                end
            end
            else if (c == "." && !wrap8)
                v.stage = ST_FRAC;
            else
                v.stage = ST_STOP;
        end
        else if (v.stage == ST_FRAC)
        begin
            if (dig)
            begin
                if (v.frac == 0) v.mag += d * 10;
                else if (v.frac == 1) v.mag += d;
                if (v.frac < 2) v.frac++;
                if (v.mag > MAG_CAP) v.mag = MAG_CAP;
            end
            else
                v.stage = ST_STOP;
        end
    endfunction

    function automatic bit key_hit(int k);
        int n;
        n = key_str[k].len();
        if (n > WIN_BYTES) return 0;
        for (int i = 0; i < n; i++)
            if (win[WIN_BYTES - n + i] != key_str[k][i]) return 0;
        return 1;
    endfunction

    function automatic logic signed [22:0] temp_val(int k);
        int unsigned m;
        m = vals[k].mag;
        if (phase[k] == PH_SEARCH) return 0;
        if (vals[k].neg)
        begin
            if (m > TEMP_NEG_MAX) m = TEMP_NEG_MAX;
            return -$signed({1'b0, m[22:0]});
        end
        if (m > TEMP_POS_MAX) m = TEMP_POS_MAX;
        return m[22:0];
    endfunction

    function automatic logic [15:0] load_val(int k);
        int unsigned w;
        if (phase[k] == PH_SEARCH || vals[k].neg) return 0;
        w = vals[k].mag / 100;
        return (w > 65535) ? 16'hFFFF : w[15:0];
    endfunction

    // advance the parser copy by one byte, queue a report on the last one
    function automatic void parse_byte(byte unsigned c, bit last);
        res_t r;
        byte unsigned term;
        int unsigned m;
        if (!text_end)
        begin
            if (c == 0)
                text_end = 1;
            else
            begin
                for (int k = 0; k < NUM_VALS; k++)
                    if (phase[k] == PH_VALUE)
                    begin
                        if (c == ",") phase[k] = PH_DONE;
                        else num_take(vals[k], c, 0);
                    end
                if (phase[5] == PH_VALUE && tidx < 3)
                begin
                    term = (tidx < 2) ? "-" : 8'h0A;
                    if (c == term)
                    begin
                        tidx++;
                        if (tidx >= 3) phase[5] = PH_DONE;
                    end
                    else
                        num_take(tfld[tidx], c, 1);
                end
                for (int i = 0; i < WIN_BYTES - 1; i++) win[i] = win[i + 1];
                win[WIN_BYTES - 1] = c;
                for (int k = 0; k < 6; k++)
                    if (phase[k] == PH_SEARCH && key_hit(k)) phase[k] = PH_VALUE;
            end
        end
        if (!last) return;
        r.time_seen = (phase[5] != PH_SEARCH);
        if (r.time_seen)
            for (int f = 0; f < 3; f++)
            begin
                m = tfld[f].mag & 8'hFF;
                hold_t[f] = tfld[f].neg ? 8'(0 - m) : m[7:0];
            end
        r.cpu_temp_centi = temp_val(0);
        r.cpu_load = load_val(1);
        r.gpu_temp_centi = temp_val(2);
        r.gpu_load = load_val(3);
        r.ram_usage = load_val(4);
        r.time_hour = hold_t[0];
        r.time_minute = hold_t[1];
        r.time_second = hold_t[2];
        pending_reports.push_back(r);
        msg_clear();
    endfunction

    // send one byte; bursts with random gaps once the sender is on
    task automatic send_byte(byte unsigned c, bit last);
        if (sender_on && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        parse_byte(c, last);
        bytes_sent++;
    endtask

    task automatic send_text(string s, bit close = 1);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], close && (i == s.len() - 1));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
    endtask

    // receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (long_stall)
            m_axis_tready <= 1'b0;
        else if (cycles % 512 < 128)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    // report checker
    always @(posedge clk)
    begin
        res_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[22:0], m_axis_tdata[38:23], m_axis_tdata[61:39],
                   m_axis_tdata[77:62], m_axis_tdata[93:78], m_axis_tdata[101:94],
                   m_axis_tdata[109:102], m_axis_tdata[117:110], m_axis_tdata[118]};
            reports_seen++;
            if (pending_reports.size() == 0)
            begin
                $error("report with none expected");
                errors++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got.cpu_temp_centi !== want.cpu_temp_centi)
                begin
                    $error("cpu_temp_centi exp %0d got %0d", want.cpu_temp_centi,
                        got.cpu_temp_centi);
                    errors++;
                end
                if (got.cpu_load !== want.cpu_load)
                begin
                    $error("cpu_load exp %0d got %0d", want.cpu_load, got.cpu_load);
                    errors++;
                end
                if (got.gpu_temp_centi !== want.gpu_temp_centi)
                begin
                    $error("gpu_temp_centi exp %0d got %0d", want.gpu_temp_centi,
                        got.gpu_temp_centi);
                    errors++;
                end
                if (got.gpu_load !== want.gpu_load)
                begin
                    $error("gpu_load exp %0d got %0d", want.gpu_load, got.gpu_load);
                    errors++;
                end
                if (got.ram_usage !== want.ram_usage)
                begin
                    $error("ram_usage exp %0d got %0d", want.ram_usage, got.ram_usage);
                    errors++;
                end
                if (got.time_hour !== want.time_hour)
                begin
                    $error("time_hour exp %0d got %0d", want.time_hour, got.time_hour);
                    errors++;
                end
                if (got.time_minute !== want.time_minute)
                begin
                    $error("time_minute exp %0d got %0d", want.time_minute,
                        got.time_minute);
                    errors++;
                end
                if (got.time_second !== want.time_second)
                begin
                    $error("time_second exp %0d got %0d", want.time_second,
                        got.time_second);
                    errors++;
                end
                if (got.time_seen !== want.time_seen)
                begin
                    $error("time_seen exp %0d got %0d", want.time_seen, got.time_seen);
                    errors++;
                end
            end
        end
    end

    // random number text, sometimes malformed
    function automatic string rand_num();
        string s;
        int n;
        s = "";
        n = $urandom_range(0, 3);
        repeat (n)
        begin
            if ($urandom_range(0, 1)) s = {s, " "};
            else s = {s, "\t"};
        end
        case ($urandom_range(0, 3))
            0: s = {s, "-"};
            1: s = {s, "+"};
            default: ;
        endcase
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
        repeat (n) s = {s, string'(byte'(8'h30 + $urandom_range(0, 9)))};
        if ($urandom_range(0, 1))
        begin
            s = {s, "."};
            repeat ($urandom_range(0, 4)) s = {s, string'(byte'(8'h30 + $urandom_range(0, 9)))};
        end
        if ($urandom_range(0, 7) == 0) s = {s, "x9"};
        return s;
    endfunction

    function automatic string rand_int8();
        string s;
        s = "";
        if ($urandom_range(0, 5) == 0) s = " ";
        repeat ($urandom_range(0, 4)) s = {s, string'(byte'(8'h30 + $urandom_range(0, 9)))};
        return s;
    endfunction

    function automatic string rand_message();
        string s;
        string sec;
        string parts[$];
        parts.push_back({"CPUTemp:", rand_num(), ","});
        parts.push_back({"CPULoad:", rand_num(), ","});
        parts.push_back({"GPUTemp:", rand_num(), ","});
        parts.push_back({"GPULoad:", rand_num(), ","});
        parts.push_back({"RAM:", rand_num(), ","});
        if ($urandom_range(0, 2) != 0)
        begin
            sec = "";
            if ($urandom_range(0, 1)) sec = "-";
            parts.push_back({"Time:", rand_int8(), "-", rand_int8(), "-",
                sec, rand_int8(), "\n"});
        end
        parts.shuffle();
        s = "";
        foreach (parts[i])
            if ($urandom_range(0, 5) != 0) s = {s, parts[i]};
        // noise bytes
        repeat ($urandom_range(0, 2))
            s = {s, string'(byte'($urandom_range(1, 255)))};
        if (s.len() == 0) s = "x";
        if ($urandom_range(0, 4) == 0) s = s.substr(0, s.len() - 2 - (s.len() > 1 ? 0 : -1));
        return s;
    endfunction

    // message with a zero byte inside, then more text up to the last byte
    task automatic send_with_zero(string head, string tail);
        send_text(head, 0);
        send_byte(8'h00, 0);
        send_text(tail);
    endtask

    task automatic test_directed();
        send_text("CPUTemp:45.678,CPULoad:12.9,GPUTemp:-3.5,GPULoad:99,RAM:4096,Time:12-34-56\n");
        send_text("CPUTemp:99999999,CPULoad:-5,GPUTemp:-99999999,GPULoad:70000,RAM:  +.5");
        send_text("RAM:1,RAM:2,CPULoad:1CPUTemp:7,Time:300-255--4\n");
        send_text("CPULoad:.,GPULoad:+,GPUTemp:\t\r -.09,Time:7-");
        send_with_zero("CPULoad:12", "9,Time:1-2-3\n");
        send_text({string'(byte'(8'hFF)), string'(byte'(8'h80)), "junk"});
        send_byte(8'h00, 1);
        send_byte(8'hFF, 1);
        drain();
    endtask

    task automatic test_random(int n);
        while (bytes_sent < n)
        begin
            if ($urandom_range(0, 15) == 0)
                send_with_zero(rand_message(), "CPULoad:5,");
            else
                send_text(rand_message());
        end
        drain();
    endtask

    task automatic test_backpressure();
        fork
            begin
                long_stall = 1;
                repeat (300) @(posedge clk);
                long_stall = 0;
            end
            repeat (8) send_text("RAM:3,Time:1-2-3\n");
        join
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        cycles = 0;
        errors = 0;
        bytes_sent = 0;
        reports_seen = 0;
        long_stall = 0;
        sender_on = 0;
        foreach (hold_t[i]) hold_t[i] = 0;
        msg_clear();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        sender_on = 1;
        test_backpressure();
        test_random(1000);
        repeat (20) @(posedge clk);
        $display("covered %0d bytes in %0d reports: directed, stall, random messages",
            bytes_sent, reports_seen);
        if (errors == 0 && pending_reports.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
